>>> design/srpq_pkg.sv
`timescale 1ns / 1ps

package srpq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic first;
    logic last;
  } cell_ctrl_t;

endpackage

>>> design/srpq_if.sv
`timescale 1ns / 1ps

interface srpq_cmd_if #(
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16
) ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [KEY_BITS-1:0]     key;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, output command, output key, output payload, input ready);
  modport sink   (input valid, input command, input key, input payload, output ready);
endinterface

interface srpq_res_if #(
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16
) ();
  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    is_empty;
  logic                    is_full;

  modport source (output valid, output accepted, output out_key, output out_payload,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input accepted, input out_key, input out_payload,
                  input is_empty, input is_full, output ready);
endinterface

>>> design/srpq_cell.sv
`timescale 1ns / 1ps

module srpq_cell
  import srpq_pkg::*;
#(
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic                    occupied,
  input  logic [KEY_BITS-1:0]     new_key,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic                    left_gt,
  input  logic [KEY_BITS-1:0]     left_key,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic [KEY_BITS-1:0]     right_key,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  output logic                    gt,
  output logic [KEY_BITS-1:0]     key,
  output logic [PAYLOAD_BITS-1:0] payload
);

  logic [KEY_BITS-1:0]     key_next;
  logic [PAYLOAD_BITS-1:0] payload_next;

  assign gt = occupied && (key > new_key);

  always_comb begin
    key_next     = key;
    payload_next = payload;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (left_gt && !ctrl.first) begin
          key_next     = left_key;
          payload_next = left_payload;
        end else if (gt || !occupied) begin
          key_next     = new_key;
          payload_next = new_payload;
        end
      end
      OP_REMOVE: begin
        if (!ctrl.last) begin
          key_next     = right_key;
          payload_next = right_payload;
        end
      end
      default: begin
        key_next     = key;
        payload_next = payload;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key     <= key_next;
    payload <= payload_next;
  end

endmodule

>>> design/sorted_ring_priority_queue.sv
`timescale 1ns / 1ps
// A result is presented in the cycle after its command transfer.
// Throughput: one command per cycle while results are taken; every cell compares
// its key with the new key in parallel and shifts one place toward its neighbor.
// Reset: synchronous, clears the occupancy count and the result valid; cell contents
// are not reset and are never read before they are written.
module sorted_ring_priority_queue
  import srpq_pkg::*;
#(
  parameter int SLOTS        = 256,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  srpq_cmd_if.sink   cmd,
  srpq_res_if.source res
);

  localparam int CELLS = SLOTS - 1;
  localparam int CW    = $clog2(SLOTS);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          xfer;
  logic          full;
  logic          empty;
  logic          do_insert;
  logic          do_remove;
  op_t           op;

  logic                    gt_c      [CELLS];
  logic [KEY_BITS-1:0]     key_c     [CELLS];
  logic [PAYLOAD_BITS-1:0] payload_c [CELLS];

  assign cmd.ready = !res.valid || res.ready;
  assign xfer      = cmd.valid && cmd.ready;
  assign full      = (count == CW'(SLOTS - 1));
  assign empty     = (count == '0);
  assign do_insert = xfer && (cmd.command == CMD_INSERT) && !full;
  assign do_remove = xfer && (cmd.command == CMD_REMOVE) && !empty;

  always_comb begin
    op         = OP_HOLD;
    count_next = count;
    priority if (do_insert) begin
      op         = OP_INSERT;
      count_next = count + 1'b1;
    end else if (do_remove) begin
      op         = OP_REMOVE;
      count_next = count - 1'b1;
    end
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.op    = op;
    assign ctrl.first = (i == 0);
    assign ctrl.last  = (i == CELLS - 1);

    srpq_cell #(
      .KEY_BITS    (KEY_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occupied     (CW'(i) < count),
      .new_key      (cmd.key),
      .new_payload  (cmd.payload),
      .left_gt      (gt_c[(i == 0) ? 0 : i - 1]),
      .left_key     (key_c[(i == 0) ? 0 : i - 1]),
      .left_payload (payload_c[(i == 0) ? 0 : i - 1]),
      .right_key    (key_c[(i == CELLS - 1) ? i : i + 1]),
      .right_payload(payload_c[(i == CELLS - 1) ? i : i + 1]),
      .gt           (gt_c[i]),
      .key          (key_c[i]),
      .payload      (payload_c[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (xfer) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      res.accepted    <= do_insert || do_remove;
      res.out_key     <= do_remove ? key_c[0] : '0;
      res.out_payload <= do_remove ? payload_c[0] : '0;
      res.is_empty    <= (count_next == '0);
      res.is_full     <= (count_next == CW'(SLOTS - 1));
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS - 1))
    else $error("occupancy above capacity");

  a_empty_remove_refused: assert property (@(posedge clk) disable iff (rst)
    (xfer && cmd.command == CMD_REMOVE && empty) |=> (!res.accepted && res.is_empty))
    else $error("remove from empty queue not refused");

  a_full_insert_refused: assert property (@(posedge clk) disable iff (rst)
    (xfer && cmd.command == CMD_INSERT && full) |=> (!res.accepted && res.is_full))
    else $error("insert into full queue not refused");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    do_remove |=> (count == $past(count) - 1'b1))
    else $error("occupancy not decremented on remove");

  a_status_exclusive: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.is_empty && res.is_full))
    else $error("queue reported both empty and full");

endmodule
